// ----- design/dccs_pkg.sv -----
package dccs_pkg;

  localparam int unsigned NumRegs = 8;
  localparam int unsigned AddrW   = 5;

  localparam logic [2:0] RegCondEn     = 3'd0;
  localparam logic [2:0] RegMinInLim   = 3'd1;
  localparam logic [2:0] RegCableMask  = 3'd2;
  localparam logic [2:0] RegDisBatCur  = 3'd3;
  localparam logic [2:0] RegEnaBatCur  = 3'd4;
  localparam logic [2:0] RegMainPct    = 3'd5;
  localparam logic [2:0] RegSubPct     = 3'd6;
  localparam logic [2:0] RegSubCap     = 3'd7;

  localparam logic        SerialTopology = 1'b0;

  localparam logic signed [15:0] EnaBatCurRst = 16'sd2200;
  localparam logic [7:0]         PctRst       = 8'd100;
  localparam logic [16:0]        SubCapRst    = 17'd100000;

  // x / 100 == (x * PctRecip) >> PctShift for any x below 2^23
  localparam int unsigned  ProdW    = 23;
  localparam int unsigned  RecipW   = 24;
  localparam logic [23:0]  PctRecip = 24'd10737419;
  localparam int unsigned  PctShift = 30;

  typedef struct packed {
    logic [15:0]        total_input_limit;
    logic [15:0]        total_charge_current;
    logic [4:0]         cable_kind;
    logic               main_in_cv;
    logic signed [15:0] battery_current;
    logic               charging_active;
    logic               new_cable;
  } in_req_t;

  typedef struct packed {
    logic        sub_enabled;
    logic        sub_toggled;
    logic [15:0] main_input_out;
    logic [15:0] sub_input_out;
    logic [15:0] main_charge_out;
    logic [16:0] sub_charge_out;
  } out_req_t;

  typedef struct packed {
    logic [3:0]         condition_enables;
    logic [15:0]        min_input_limit;
    logic [31:0]        allowed_cable_mask;
    logic signed [15:0] disable_battery_current;
    logic signed [15:0] enable_battery_current;
    logic [7:0]         main_level_percent;
    logic [7:0]         sub_level_percent;
    logic [16:0]        sub_current_cap;
  } cfg_t;

  typedef struct packed {
    in_req_t       req;
    logic [ProdW-1:0] main_prod;
    logic [ProdW-1:0] sub_prod;
  } prep_t;

endpackage

// ----- design/dccs_cfg.sv -----
module dccs_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dccs_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output dccs_pkg::cfg_t              cfg_o
);
  import dccs_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegCondEn:    cfg_d.condition_enables       = pwdata[3:0];
        RegMinInLim:  cfg_d.min_input_limit         = pwdata[15:0];
        RegCableMask: cfg_d.allowed_cable_mask      = pwdata;
        RegDisBatCur: cfg_d.disable_battery_current = pwdata[15:0];
        RegEnaBatCur: cfg_d.enable_battery_current  = pwdata[15:0];
        RegMainPct:   cfg_d.main_level_percent      = pwdata[7:0];
        RegSubPct:    cfg_d.sub_level_percent       = pwdata[7:0];
        RegSubCap:    cfg_d.sub_current_cap         = pwdata[16:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegCondEn:    prdata = {28'd0, cfg_q.condition_enables};
      RegMinInLim:  prdata = {16'd0, cfg_q.min_input_limit};
      RegCableMask: prdata = cfg_q.allowed_cable_mask;
      RegDisBatCur: prdata = {16'd0, cfg_q.disable_battery_current};
      RegEnaBatCur: prdata = {16'd0, cfg_q.enable_battery_current};
      RegMainPct:   prdata = {24'd0, cfg_q.main_level_percent};
      RegSubPct:    prdata = {24'd0, cfg_q.sub_level_percent};
      RegSubCap:    prdata = {15'd0, cfg_q.sub_current_cap};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.condition_enables       <= '0;
      cfg_q.min_input_limit         <= '0;
      cfg_q.allowed_cable_mask      <= '0;
      cfg_q.disable_battery_current <= '0;
      cfg_q.enable_battery_current  <= EnaBatCurRst;
      cfg_q.main_level_percent      <= PctRst;
      cfg_q.sub_level_percent       <= PctRst;
      cfg_q.sub_current_cap         <= SubCapRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- design/dccs_prep.sv -----
module dccs_prep (
  input  logic              clk_i,
  input  logic              load_i,
  input  dccs_pkg::in_req_t req_i,
  input  dccs_pkg::cfg_t    cfg_i,
  output dccs_pkg::prep_t   prep_o
);
  import dccs_pkg::*;

  prep_t       prep_q, prep_d;
  logic [14:0] half;

  // half share times percent; the divide by 100 follows in the next stage
  assign half = req_i.total_charge_current[15:1];

  always_comb begin
    prep_d.req       = req_i;
    prep_d.main_prod = ProdW'(half) * ProdW'(cfg_i.main_level_percent);
    prep_d.sub_prod  = ProdW'(half) * ProdW'(cfg_i.sub_level_percent);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prep_q <= prep_d;
    end
  end

  assign prep_o = prep_q;

endmodule

// ----- design/dccs_share.sv -----
module dccs_share (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  dccs_pkg::prep_t    prep_i,
  input  dccs_pkg::cfg_t     cfg_i,
  output dccs_pkg::out_req_t res_o
);
  import dccs_pkg::*;

  out_req_t res_q, res_d;
  logic     run_q, run_d;
  logic     run_prev, pass;
  logic [3:0] en;
  logic [ProdW+RecipW-1:0] main_full, sub_full;
  logic [16:0] main_q100, sub_q100;
  logic [16:0] diff;
  in_req_t     r;

  assign r  = prep_i.req;
  assign en = cfg_i.condition_enables;

  assign main_full = (ProdW + RecipW)'(prep_i.main_prod) * (ProdW + RecipW)'(PctRecip);
  assign sub_full  = (ProdW + RecipW)'(prep_i.sub_prod) * (ProdW + RecipW)'(PctRecip);
  assign main_q100 = main_full[PctShift +: 17];
  assign sub_q100  = sub_full[PctShift +: 17];

  assign run_prev = r.new_cable ? 1'b0 : run_q;

  always_comb begin
    pass = (en != 4'd0);
    if (en[0] && (r.total_input_limit < cfg_i.min_input_limit)) pass = 1'b0;
    if (en[1] && !cfg_i.allowed_cable_mask[r.cable_kind]) pass = 1'b0;
    if (en[2] && r.main_in_cv) pass = 1'b0;
    if (en[3]) begin
      if (r.battery_current < cfg_i.disable_battery_current) pass = 1'b0;
      if ((r.battery_current < cfg_i.enable_battery_current) && !run_prev) pass = 1'b0;
    end
  end

  assign run_d = r.charging_active ? pass : run_prev;
  assign diff  = {1'b0, r.total_charge_current} - cfg_i.sub_current_cap;

  always_comb begin
    res_d.sub_enabled = run_d;
    res_d.sub_toggled = r.charging_active && (run_d != run_prev);
    if (run_d && !SerialTopology) begin
      res_d.main_input_out = {1'b0, r.total_input_limit[15:1]};
      res_d.sub_input_out  = {1'b0, r.total_input_limit[15:1]};
    end else begin
      res_d.main_input_out = r.total_input_limit;
      res_d.sub_input_out  = '0;
    end
    if (!run_d) begin
      res_d.main_charge_out = r.total_charge_current;
      res_d.sub_charge_out  = '0;
    end else if (sub_q100 > cfg_i.sub_current_cap) begin
      res_d.sub_charge_out = cfg_i.sub_current_cap;
      if ({1'b0, r.total_charge_current} > cfg_i.sub_current_cap) begin
        res_d.main_charge_out = diff[15:0];
      end else begin
        res_d.main_charge_out = '0;
      end
    end else begin
      res_d.sub_charge_out = sub_q100;
      if (main_q100[16]) begin
        res_d.main_charge_out = 16'hFFFF;
      end else begin
        res_d.main_charge_out = main_q100[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (load_i) begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- design/dual_charger_current_sharing.sv -----
// An accepted request is held in dccs_prep's input register, then in dccs_share's result
//   register, where out_valid_o marks it until it leaves.
// Throughput: one request per cycle while out_stall_i is low; the input and result
//   registers form a two-entry pipeline, so a new request is taken while a result waits.
// Reset (rst_ni low, asynchronous): pipeline empty, secondary charger off, configuration
//   registers back to their defaults.
module dual_charger_current_sharing (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  dccs_pkg::in_req_t          in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output dccs_pkg::out_req_t         out_req_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dccs_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import dccs_pkg::*;

  cfg_t  cfg;
  prep_t prep;
  logic  s1_valid_q, s1_valid_d;
  logic  out_valid_q, out_valid_d;
  logic  out_free, s1_adv, in_acc;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_adv      = s1_valid_q && out_free;
  assign in_stall_o  = s1_valid_q && !out_free;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_acc || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  dccs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dccs_prep u_prep (
    .clk_i  (clk_i),
    .load_i (in_acc),
    .req_i  (in_req_i),
    .cfg_i  (cfg),
    .prep_o (prep)
  );

  dccs_share u_share (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (s1_adv),
    .prep_i (prep),
    .cfg_i  (cfg),
    .res_o  (out_req_o)
  );

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && s1_valid_q))
    else $error("input stalled with room in pipeline");

  a_off_gets_nothing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_req_o.sub_enabled) |->
      (out_req_o.sub_charge_out == 17'd0 && out_req_o.sub_input_out == 16'd0))
    else $error("secondary share while secondary off");

  a_sub_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.sub_charge_out <= cfg.sub_current_cap))
    else $error("secondary charge above cap");

  a_toggle_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (out_req_o.sub_toggled == 1'b0 ||
                out_req_o.sub_enabled != $past(u_share.run_q)
                || $past(prep.req.new_cable)))
    else $error("toggle without change of enable");

endmodule
